// ----- hdl/srecord_line_checker_macros.svh -----
// ----------------------------------------------------------------------------
// S-record line checker assertion macros
// Concurrent assertion shorthands clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SRECORD_LINE_CHECKER_MACROS_SVH
`define SRECORD_LINE_CHECKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SRLC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SRLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRLC_ASSERT_IMPL(lbl, ante, cons, msg)
`define SRLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/srlc_pkg.sv -----
// ----------------------------------------------------------------------------
// S-record line checker package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package srlc_pkg;

   // line position saturates here
   localparam int unsigned POS_W   = 10;
   localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

   // queue between classifier and line engine
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;
   localparam int unsigned QUEUE_LW    = QUEUE_AW + 1;

   // character codes
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;

   // record types
   localparam logic [3:0] TYPE_S0 = 4'h0;
   localparam logic [3:0] TYPE_S1 = 4'h1;
   localparam logic [3:0] TYPE_S2 = 4'h2;
   localparam logic [3:0] TYPE_S3 = 4'h3;
   localparam logic [3:0] TYPE_S5 = 4'h5;

   // good checksum total
   localparam logic [7:0] SUM_GOOD = 8'hFF;

   // padding bits of the result beat
   localparam int unsigned RSP_PAD_W = 7;

   // one classified character
   typedef struct packed {
      logic [3:0] nib;
      logic       upper_hex;
      logic       is_s;
      logic       eol;
   } entry_type;

   // queue status toward the top level
   typedef struct packed {
      logic [QUEUE_LW-1:0] level;
      logic                full;
      logic                empty;
   } queue_status_type;

   // one line result, record_type in the lowest bits
   typedef struct packed {
      logic        checksum_ok;
      logic        length_ok;
      logic        hex_ok;
      logic        start_ok;
      logic [7:0]  rec_count;
      logic [31:0] address;
      logic        type_supported;
      logic [3:0]  record_type;
   } result_type;

   // number of address bytes per record type
   function automatic logic [2:0] addr_bytes(input logic [3:0] t);
      logic [2:0] n;
      n = 3'd0;
      unique case (t)
         TYPE_S1: n = 3'd2;
         TYPE_S2: n = 3'd3;
         TYPE_S3: n = 3'd4;
         TYPE_S5: n = 3'd2;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic type_ok(input logic [3:0] t);
      return (t == TYPE_S0) || (t == TYPE_S1) || (t == TYPE_S2) ||
             (t == TYPE_S3) || (t == TYPE_S5);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/srlc_front.sv -----
// ----------------------------------------------------------------------------
// S-record line checker front end
// Accepts character beats and classifies them for the line engine.
// ----------------------------------------------------------------------------
`default_nettype none

module srlc_front (
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] char_code
   input  wire logic               req_tlast,   // end_of_line
   input  wire logic               queue_full,
   output logic                    push,
   output srlc_pkg::entry_type     push_entry
);

   logic is_digit;
   logic is_upper;
   logic is_lower;

   // character class decode
   assign is_digit = (req_tdata >= srlc_pkg::CHAR_0)    && (req_tdata <= srlc_pkg::CHAR_9);
   assign is_upper = (req_tdata >= srlc_pkg::CHAR_UP_A) && (req_tdata <= srlc_pkg::CHAR_UP_F);
   assign is_lower = (req_tdata >= srlc_pkg::CHAR_LO_A) && (req_tdata <= srlc_pkg::CHAR_LO_F);

   // nibble value, zero for non-hex
   always_comb begin
      push_entry.nib = 4'd0;
      priority if (is_digit) begin
         push_entry.nib = 4'(req_tdata - srlc_pkg::CHAR_0);
      end else if (is_upper) begin
         push_entry.nib = 4'(req_tdata - srlc_pkg::CHAR_UP_A + 8'd10);
      end else if (is_lower) begin
         push_entry.nib = 4'(req_tdata - srlc_pkg::CHAR_LO_A + 8'd10);
      end else begin
         push_entry.nib = 4'd0;
      end
      push_entry.upper_hex = is_digit | is_upper;
      push_entry.is_s      = (req_tdata == srlc_pkg::CHAR_S);
      push_entry.eol       = req_tlast;
   end

   // handshake into the queue
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

`default_nettype wire

// ----- hdl/srlc_queue.sv -----
// ----------------------------------------------------------------------------
// S-record line checker queue
// Small FIFO of classified characters between front end and line engine.
// ----------------------------------------------------------------------------
`default_nettype none

module srlc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire srlc_pkg::entry_type   push_entry,
   input  wire logic                  pop,
   output srlc_pkg::entry_type        head,
   output srlc_pkg::queue_status_type status
);

   srlc_pkg::entry_type                 mem_ff [srlc_pkg::QUEUE_DEPTH];
   logic [srlc_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [srlc_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [srlc_pkg::QUEUE_LW-1:0]       level_ff, level_in;
   logic                                do_push;
   logic                                do_pop;

   assign status.level = level_ff;
   assign status.full  = (level_ff == srlc_pkg::QUEUE_LW'(srlc_pkg::QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/srlc_back.sv -----
// ----------------------------------------------------------------------------
// S-record line checker line engine
// Tracks line state per character and registers one result per line.
// ----------------------------------------------------------------------------
`default_nettype none

module srlc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire srlc_pkg::entry_type head,
   input  wire logic                queue_empty,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output srlc_pkg::result_type     rsp_result
);

   logic [srlc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [3:0]                 type_ff, type_in;
   logic [7:0]                 count_ff, count_in;
   logic [31:0]                addr_ff, addr_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [3:0]                 high_ff, high_in;
   logic                       bad_ff, bad_in;
   logic                       start_ff, start_in;
   logic                       valid_ff, valid_in;
   srlc_pkg::result_type       result_ff, result_in;

   logic [7:0]                 byte_val;
   logic [8:0]                 half_pos;
   logic [2:0]                 nbytes;
   logic [10:0]                len_want;
   logic                       can_take;

   assign byte_val = {high_ff, head.nib};
   assign half_pos = pos_ff[srlc_pkg::POS_W-1:1];
   assign nbytes   = srlc_pkg::addr_bytes(type_ff);

   // end-of-line beat waits for a free output register
   assign can_take = !head.eol || !valid_ff || rsp_tready;
   assign pop      = !queue_empty && can_take;

   // line state update
   always_comb begin
      pos_in    = pos_ff;
      type_in   = type_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      sum_in    = sum_ff;
      high_in   = high_ff;
      bad_in    = bad_ff;
      start_in  = start_ff;
      result_in = result_ff;
      len_want  = '0;
      valid_in  = valid_ff && !rsp_tready;

      if (pop) begin
         // start character and hex check
         if (pos_ff == '0) begin
            start_in = head.is_s;
         end else if (!head.upper_hex) begin
            bad_in = 1'b1;
         end

         if (pos_ff == srlc_pkg::POS_W'(1)) begin
            type_in = head.nib;
         end

         // byte pairs from the third character on
         if ((pos_ff >= srlc_pkg::POS_W'(2)) && (pos_ff < srlc_pkg::POS_MAX)) begin
            if (!pos_ff[0]) begin
               high_in = head.nib;
            end else begin
               sum_in = sum_ff + byte_val;
               if (pos_ff == srlc_pkg::POS_W'(3)) begin
                  count_in = byte_val;
               end
               if ((half_pos >= 9'd2) && (half_pos <= ({6'd0, nbytes} + 9'd1))) begin
                  addr_in = {addr_ff[23:0], byte_val};
               end
            end
         end

         if (pos_ff != srlc_pkg::POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end

         // line done: build result, clear state
         if (head.eol) begin
            len_want                 = {2'b00, count_in, 1'b0} + 11'd4;
            result_in.record_type    = type_in;
            result_in.type_supported = srlc_pkg::type_ok(type_in);
            result_in.address        = (srlc_pkg::addr_bytes(type_in) != 3'd0) ? addr_in : '0;
            result_in.rec_count      = count_in;
            result_in.start_ok       = start_in;
            result_in.hex_ok         = !bad_in;
            result_in.length_ok      = ({1'b0, pos_in} == len_want);
            result_in.checksum_ok    = (sum_in == srlc_pkg::SUM_GOOD);
            valid_in                 = 1'b1;
            pos_in                   = '0;
            type_in                  = '0;
            count_in                 = '0;
            addr_in                  = '0;
            sum_in                   = '0;
            high_in                  = '0;
            bad_in                   = 1'b0;
            start_in                 = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         type_ff  <= '0;
         count_ff <= '0;
         addr_ff  <= '0;
         sum_ff   <= '0;
         high_ff  <= '0;
         bad_ff   <= 1'b0;
         start_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         type_ff  <= type_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         bad_ff   <= bad_in;
         start_ff <= start_in;
         valid_ff <= valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ----- hdl/srecord_line_checker.sv -----
// ----------------------------------------------------------------------------
// S-record line checker
// Checks one Motorola S-record line per run of character beats.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one ASCII character per beat in req_tdata; req_tlast marks
//   the final character of a line. rsp_* carries one result beat per line.
//   Throughput is one character per cycle while req_tready is high; a result beat does not hold up characters.
//   A line's last character is written into the character queue when it is
//   accepted, and the line engine registers the result when it pops that
//   beat from the queue.
//   A four-entry queue sits between the classifier and the line engine, so
//   characters keep coming in while a result waits on rsp_tready; once the
//   queue holds four beats behind a stalled result, req_tready drops.
//   Reset (synchronous, active high) clears the queue, all line state and
//   the result valid flag; the first beat after reset starts a new line.
//   Lines longer than 1023 characters saturate the position and fail the
//   length check.
// ----------------------------------------------------------------------------
`default_nettype none

`include "srecord_line_checker_macros.svh"

module srecord_line_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_line
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // [3:0] record_type, [4] type_supported,
                                         // [36:5] address, [44:37] rec_count,
                                         // [45] start_ok, [46] hex_ok,
                                         // [47] length_ok, [48] checksum_ok
);

   srlc_pkg::entry_type        push_entry;
   srlc_pkg::entry_type        head;
   srlc_pkg::queue_status_type qstat;
   srlc_pkg::result_type       result;
   logic                       push;
   logic                       pop;

   srlc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (qstat.full),
      .push       (push),
      .push_entry (push_entry)
   );

   srlc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   srlc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (qstat.empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_result  (result)
   );

   assign rsp_tdata = {{srlc_pkg::RSP_PAD_W{1'b0}}, result};

   // checks
   `SRLC_ASSERT_IMPL(a_level_bound, 1'b1,
      qstat.level <= srlc_pkg::QUEUE_LW'(srlc_pkg::QUEUE_DEPTH), "queue level overflow")
   `SRLC_ASSERT_NEXT(a_push_fills, push && !pop, !qstat.empty, "pushed beat lost")
   `SRLC_ASSERT_IMPL(a_result_from_eol, $rose(rsp_tvalid),
      $past(pop) && $past(head.eol), "result without end of line")
   `SRLC_ASSERT_NEXT(a_eol_stall, !qstat.empty && head.eol && rsp_tvalid && !rsp_tready,
      rsp_tvalid, "result dropped while stalled")

endmodule

`default_nettype wire
